// File: rtl/core/assert_macros.svh
// assertion macros used by the rtl top, hashed_timer_wheel.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define HTW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define HTW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/core/htw_pkg.sv
// timer wheel package: sizes, codes and divider interface types
// no dependencies
package htw_pkg;

	localparam int TIMERS      = 64;
	localparam int SLOTS       = 4096;
	localparam int MAX_RESULTS = 64;

	localparam int ID_W   = $clog2(TIMERS);
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int LINK_W = ID_W + 1;
	localparam int PREV_W = SLOT_W + 1;
	localparam int CNT_W  = 7;
	localparam int RES_W  = 16;
	localparam int WS_W   = 13;
	localparam int DIV_W  = 33;
	localparam int DVS_W  = 16;

	localparam logic [LINK_W-1:0] NIL = LINK_W'(TIMERS);

	localparam logic [1:0] KIND_ADD  = 2'd0;
	localparam logic [1:0] KIND_DEL  = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;

	localparam logic [1:0] CFG_RES   = 2'd0;
	localparam logic [1:0] CFG_SLOTS = 2'd1;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
		logic [DVS_W-1:0] rem;
	} div_rsp_t;

endpackage

// File: rtl/core/htw_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on htw_pkg
module htw_div import htw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int STEP_W = $clog2(DIV_W + 1);

	logic [DVS_W-1:0]  rem_q;
	logic [DIV_W-1:0]  quot_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DVS_W:0]    trial;
	logic [DVS_W:0]    diff;

	assign trial = {rem_q, quot_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == STEP_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			quot_q <= req.dividend;
			dvs_q  <= req.divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, dvs_q}) begin
				rem_q  <= diff[DVS_W-1:0];
				quot_q <= {quot_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q  <= trial[DVS_W-1:0];
				quot_q <= {quot_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;

endmodule

// File: rtl/core/htw_engine.sv
// timer wheel engine: sequencer, slot head, timer link and deadline memories, result register
// depends on htw_pkg; uses htw_div through the div request and response structs
module htw_engine import htw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [RES_W-1:0]  eff_res,
	input  logic [WS_W-1:0]   eff_slots,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        kind,
	input  logic [ID_W-1:0]   timer_id,
	input  logic [31:0]       delay_ms,
	input  logic [31:0]       now_ms,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              fired,
	output logic [ID_W-1:0]   expired_id,
	output logic              last,
	output logic [CNT_W-1:0]  active_count,
	output logic              empty_res,
	output div_req_t          div_req,
	input  div_rsp_t          div_rsp
);

	typedef enum logic [13:0] {
		ST_CLR  = 14'b00000000000001,
		ST_IDLE = 14'b00000000000010,
		ST_RD   = 14'b00000000000100,
		ST_CAP  = 14'b00000000001000,
		ST_UNL  = 14'b00000000010000,
		ST_CHK  = 14'b00000000100000,
		ST_DGO  = 14'b00000001000000,
		ST_DWT  = 14'b00000010000000,
		ST_LK0  = 14'b00000100000000,
		ST_LK1  = 14'b00001000000000,
		ST_LK2  = 14'b00010000000000,
		ST_W0   = 14'b00100000000000,
		ST_W1   = 14'b01000000000000,
		ST_FIN  = 14'b10000000000000
	} state_t;

	state_t state_q;

	// memories
	logic [LINK_W-1:0] head_mem [SLOTS];
	logic [LINK_W-1:0] nxt_mem  [TIMERS];
	logic [PREV_W-1:0] prv_mem  [TIMERS];
	logic [31:0]       dl_mem   [TIMERS];

	logic [LINK_W-1:0] head_rd;
	logic [LINK_W-1:0] nxt_rd;
	logic [PREV_W-1:0] prv_rd;
	logic [31:0]       dl_rd;
	logic [SLOT_W-1:0] head_ra;

	logic              head_we, nxt_we, prv_we, dl_we;
	logic [SLOT_W-1:0] head_wa;
	logic [LINK_W-1:0] head_wd;
	logic [ID_W-1:0]   nxt_wa, prv_wa;
	logic [LINK_W-1:0] nxt_wd;
	logic [PREV_W-1:0] prv_wd;

	// control and operand registers
	logic [SLOT_W-1:0] clr_q;
	logic [1:0]        kind_q;
	logic [ID_W-1:0]   id_q;
	logic [ID_W-1:0]   t_q;
	logic [31:0]       now_q;
	logic [31:0]       dl_q;
	logic [1:0]        ph_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] target_q;
	logic [SLOT_W-1:0] cur_q;
	logic [SLOT_W-1:0] cur_slot_q;
	logic [LINK_W-1:0] nx_q;
	logic [PREV_W-1:0] p_q;
	logic [31:0]       dlt_q;
	logic [TIMERS-1:0] armed_q;
	logic [CNT_W-1:0]  timers_set_q;
	logic [CNT_W-1:0]  res_cnt_q;
	logic              pend_q;
	logic [ID_W-1:0]   pend_id_q;
	logic [CNT_W-1:0]  pend_cnt_q;

	logic              out_valid_q;
	logic              fired_q;
	logic [ID_W-1:0]   expired_id_q;
	logic              last_q;
	logic [CNT_W-1:0]  count_q;

	logic              accept;
	logic              out_free;
	logic [31:0]       age;
	logic              expire;
	logic              chk_wait;
	logic              unlink_go;
	logic              push;
	logic              push_fired;
	logic [ID_W-1:0]   push_id;
	logic              push_last;
	logic [CNT_W-1:0]  push_cnt;
	logic [CNT_W-1:0]  cnt_dec;
	logic              at_target;
	logic [SLOT_W-1:0] cur_inc;
	logic [SLOT_W-1:0] target_inc;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign age      = now_q - dlt_q;
	assign expire   = !age[31] && (res_cnt_q < CNT_W'(MAX_RESULTS));
	assign chk_wait = expire && pend_q && !out_free;
	assign unlink_go = (state_q == ST_UNL) ||
		((state_q == ST_CHK) && expire && !chk_wait);
	assign cnt_dec  = (timers_set_q != '0) ? timers_set_q - CNT_W'(1) : timers_set_q;

	assign at_target  = (cur_q == target_q);
	assign cur_inc    = (({1'b0, cur_q} + WS_W'(1)) == eff_slots) ? '0 : cur_q + SLOT_W'(1);
	assign target_inc = (({1'b0, target_q} + WS_W'(1)) == eff_slots) ?
		'0 : target_q + SLOT_W'(1);

	assign head_ra = (state_q == ST_W0) ? cur_q : slot_q;

	// memory write selection
	always_comb begin
		head_we = 1'b0;
		head_wa = slot_q;
		head_wd = NIL;
		nxt_we  = 1'b0;
		nxt_wa  = id_q;
		nxt_wd  = head_rd;
		prv_we  = 1'b0;
		prv_wa  = id_q;
		prv_wd  = {1'b1, slot_q};
		dl_we   = 1'b0;
		if (state_q == ST_CLR) begin
			head_we = 1'b1;
			head_wa = clr_q;
			head_wd = NIL;
		end else if (unlink_go) begin
			head_we = p_q[PREV_W-1];
			head_wa = p_q[SLOT_W-1:0];
			head_wd = nx_q;
			nxt_we  = !p_q[PREV_W-1];
			nxt_wa  = p_q[ID_W-1:0];
			nxt_wd  = nx_q;
			prv_we  = (nx_q < NIL);
			prv_wa  = nx_q[ID_W-1:0];
			prv_wd  = p_q;
		end else if (state_q == ST_LK1) begin
			head_we = 1'b1;
			head_wa = slot_q;
			head_wd = LINK_W'(id_q);
			nxt_we  = 1'b1;
			prv_we  = 1'b1;
			dl_we   = 1'b1;
		end else if (state_q == ST_LK2) begin
			prv_we = (nx_q < NIL);
			prv_wa = nx_q[ID_W-1:0];
			prv_wd = PREV_W'(id_q);
		end
	end

	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_wa] <= head_wd;
		head_rd <= head_mem[head_ra];
	end

	always_ff @(posedge clk) begin
		if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
		nxt_rd <= nxt_mem[t_q];
	end

	always_ff @(posedge clk) begin
		if (prv_we) prv_mem[prv_wa] <= prv_wd;
		prv_rd <= prv_mem[t_q];
	end

	always_ff @(posedge clk) begin
		if (dl_we) dl_mem[id_q] <= dl_q;
		dl_rd <= dl_mem[t_q];
	end

	// divider requests
	always_comb begin
		div_req.start    = (state_q == ST_DGO);
		div_req.dividend = {1'b0, now_q};
		div_req.divisor  = eff_res;
		case (ph_q)
			2'd0: begin
				if (kind_q == KIND_ADD)
					div_req.dividend = {1'b0, dl_q} + DIV_W'(eff_res) - DIV_W'(1);
			end
			2'd1: begin
				div_req.dividend = div_rsp.quot;
				div_req.divisor  = DVS_W'(eff_slots);
			end
			default: begin
				div_req.dividend = DIV_W'(cur_slot_q);
				div_req.divisor  = DVS_W'(eff_slots);
			end
		endcase
	end

	// result selection
	always_comb begin
		push       = 1'b0;
		push_fired = pend_q;
		push_id    = pend_id_q;
		push_last  = 1'b1;
		push_cnt   = pend_cnt_q;
		if ((state_q == ST_CHK) && expire && !chk_wait && pend_q) begin
			push      = 1'b1;
			push_last = 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			push = 1'b1;
			if (!pend_q) begin
				push_id  = '0;
				push_cnt = timers_set_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fired_q      <= push_fired;
			expired_id_q <= push_id;
			last_q       <= push_last;
			count_q      <= push_cnt;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			clr_q        <= '0;
			armed_q      <= '0;
			timers_set_q <= '0;
			cur_slot_q   <= '0;
			pend_q       <= 1'b0;
			res_cnt_q    <= '0;
			ph_q         <= '0;
		end else begin
			if (unlink_go) begin
				armed_q[t_q] <= 1'b0;
				timers_set_q <= cnt_dec;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + SLOT_W'(1);
					if (clr_q == SLOT_W'(SLOTS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						pend_q    <= 1'b0;
						res_cnt_q <= '0;
						ph_q      <= '0;
						unique case (kind)
							KIND_ADD: state_q <= armed_q[timer_id] ? ST_RD : ST_DGO;
							KIND_DEL: state_q <= armed_q[timer_id] ? ST_RD : ST_FIN;
							KIND_TICK: state_q <= ST_DGO;
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_RD: state_q <= ST_CAP;
				ST_CAP: state_q <= (kind_q == KIND_TICK) ? ST_CHK : ST_UNL;
				ST_UNL: state_q <= (kind_q == KIND_ADD) ? ST_DGO : ST_FIN;
				ST_CHK: begin
					if (!chk_wait) begin
						if (expire) begin
							pend_q    <= 1'b1;
							res_cnt_q <= res_cnt_q + CNT_W'(1);
						end
						if (nx_q < NIL) state_q <= ST_RD;
						else if (at_target) state_q <= ST_FIN;
						else state_q <= ST_W0;
					end
				end
				ST_DGO: state_q <= ST_DWT;
				ST_DWT: begin
					if (div_rsp.done) begin
						unique case (ph_q)
							2'd0: begin
								ph_q    <= 2'd1;
								state_q <= ST_DGO;
							end
							2'd1: begin
								if (kind_q == KIND_ADD) begin
									state_q <= ST_LK0;
								end else begin
									ph_q    <= 2'd2;
									state_q <= ST_DGO;
								end
							end
							default: state_q <= ST_W0;
						endcase
					end
				end
				ST_LK0: state_q <= ST_LK1;
				ST_LK1: begin
					armed_q[id_q] <= 1'b1;
					timers_set_q  <= timers_set_q + CNT_W'(1);
					state_q       <= ST_LK2;
				end
				ST_LK2: state_q <= ST_FIN;
				ST_W0: state_q <= ST_W1;
				ST_W1: begin
					if (head_rd < NIL) state_q <= ST_RD;
					else if (at_target) state_q <= ST_FIN;
					else state_q <= ST_W0;
				end
				ST_FIN: begin
					if (out_free) begin
						if (kind_q == KIND_TICK) cur_slot_q <= target_inc;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// operand registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			id_q   <= timer_id;
			t_q    <= timer_id;
			now_q  <= now_ms;
			dl_q   <= now_ms + delay_ms;
		end
		if (state_q == ST_CAP) begin
			nx_q  <= nxt_rd;
			p_q   <= prv_rd;
			dlt_q <= dl_rd;
		end
		if (state_q == ST_LK1) nx_q <= head_rd;
		if ((state_q == ST_DWT) && div_rsp.done) begin
			if (ph_q == 2'd1) begin
				slot_q   <= div_rsp.rem[SLOT_W-1:0];
				target_q <= div_rsp.rem[SLOT_W-1:0];
			end
			if (ph_q == 2'd2) cur_q <= div_rsp.rem[SLOT_W-1:0];
		end
		if ((state_q == ST_CHK) && !chk_wait) begin
			if (expire) begin
				pend_id_q  <= t_q;
				pend_cnt_q <= cnt_dec;
			end
			if (nx_q < NIL) t_q <= nx_q[ID_W-1:0];
			else if (!at_target) cur_q <= cur_inc;
		end
		if (state_q == ST_W1) begin
			if (head_rd < NIL) t_q <= head_rd[ID_W-1:0];
			else if (!at_target) cur_q <= cur_inc;
		end
	end

	assign out_valid    = out_valid_q;
	assign fired        = fired_q;
	assign expired_id   = expired_id_q;
	assign last         = last_q;
	assign active_count = count_q;
	assign empty_res    = (count_q == '0);

endmodule

// File: rtl/core/hashed_timer_wheel.sv
// hashed timer wheel top: configuration registers, divider and engine
// depends on htw_pkg, htw_div, htw_engine and assert_macros.svh
// sequence: delete unlinks the timer if it is set, add unlinks a set timer and then takes two divider passes,
// tick takes three divider passes and then walks the slots and visits their timers; kind 3 goes straight to the result
// one command at a time: input is stalled until the engine is back in idle, after the divider passes and the walk
// reset: a sweep that empties every slot list, input stalled until done
`include "assert_macros.svh"
module hashed_timer_wheel import htw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        kind,
	input  logic [ID_W-1:0]   timer_id,
	input  logic [31:0]       delay_ms,
	input  logic [31:0]       now_ms,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              fired,
	output logic [ID_W-1:0]   expired_id,
	output logic              last,
	output logic [CNT_W-1:0]  active_count,
	output logic              empty_res
);

	logic [RES_W-1:0] res_q;
	logic [WS_W-1:0]  slots_q;
	logic [RES_W-1:0] eff_res;
	logic [WS_W-1:0]  eff_slots;
	div_req_t         div_req;
	div_rsp_t         div_rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q   <= RES_W'(1);
			slots_q <= WS_W'(1024);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_RES) res_q <= cfg_data;
			else if (cfg_index == CFG_SLOTS) slots_q <= cfg_data[WS_W-1:0];
		end
	end

	assign eff_res   = (res_q == '0) ? RES_W'(1) : res_q;
	assign eff_slots = (slots_q == '0) ? WS_W'(1) :
		(slots_q > WS_W'(SLOTS)) ? WS_W'(SLOTS) : slots_q;

	htw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	htw_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.eff_res      (eff_res),
		.eff_slots    (eff_slots),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.timer_id     (timer_id),
		.delay_ms     (delay_ms),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.fired        (fired),
		.expired_id   (expired_id),
		.last         (last),
		.active_count (active_count),
		.empty_res    (empty_res),
		.div_req      (div_req),
		.div_rsp      (div_rsp)
	);

	`HTW_ASSERT_IMP(a_count_range, clk, arst_n, out_valid, active_count <= CNT_W'(TIMERS))
	`HTW_ASSERT_IMP(a_empty_match, clk, arst_n, out_valid, empty_res == (active_count == '0))
	`HTW_ASSERT_IMP(a_idle_beat, clk, arst_n, out_valid && !fired, last && (expired_id == '0))
	`HTW_ASSERT_NXT(a_busy_after, clk, arst_n, in_valid && !in_stall, in_stall)

endmodule
